// ===== rtl/mf3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_pkg
// Types, constants and helpers shared by the 3x3 valid-region max filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

   localparam int PIXEL_W    = 8;
   localparam int CFG_W      = 11;
   localparam int WIN        = 3;
   localparam int SIZE_RESET = 3;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // One line-buffer word: the pixels one and two rows above a column.
   typedef struct packed {
      pixel_type above2;
      pixel_type above;
   } line_pair_type;

   function automatic pixel_type max_pixel(input pixel_type a, input pixel_type b);
      return (a > b) ? a : b;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/mf3_linebuf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_linebuf
// Line buffer holding the two previous rows, one word per column, with a
// registered read port and an independent write port.
// ----------------------------------------------------------------------------
module mf3_linebuf
   import mf3_pkg::*;
#(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output line_pair_type          rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire line_pair_type     wr_data
);

   line_pair_type line_mem_ff [DEPTH];
   line_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/max_filter_3x3_valid.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_filter_3x3_valid
// 3x3 maximum filter over the valid region of a square image streamed in
// raster order; one result per pixel at row and column two or more.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Beat carries
//   req_     in         valid / stall      pixel
//   rsp_     out        valid / stall      window_max, frame_last
//   csr_     in         valid / ready      image_size (ready is always high)
//
// One pixel is accepted every cycle while req_stall is low. A result goes
// from the compute stage, beside the registered line-buffer read, to the
// output register, which takes the column and window maxima. Reset returns
// the counters and column window to zero and image_size to 3; the line
// buffer needs no clearing. While a result waits under rsp_stall, at most
// one further pixel is taken into the compute stage and then req_stall rises.
// ----------------------------------------------------------------------------
module max_filter_3x3_valid
   import mf3_pkg::*;
#(
   parameter int MAX_SIZE = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // Pixel input
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_pixel,
   // Result output
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [7:0]            rsp_window_max,
   output logic                  rsp_frame_last,
   // Configuration
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CFG_W-1:0] csr_image_size
);

   localparam int CNT_W = $clog2(MAX_SIZE);
   localparam int N_W   = $clog2(MAX_SIZE + 1);
   localparam int CMP_W = (N_W > CFG_W) ? N_W : CFG_W;

   // ---------------------------------------------------------------- config
   logic [CFG_W-1:0] size_ff;
   logic [CMP_W-1:0] size_ext;
   logic [CMP_W-1:0] side_n;
   logic             cfg_write;

   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;
   assign size_ext  = CMP_W'(size_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= CFG_W'(SIZE_RESET);
      end else if (cfg_write) begin
         size_ff <= csr_image_size;
      end
   end

   // Out-of-range sizes are clamped to the supported span.
   always_comb begin
      if (size_ext < CMP_W'(WIN)) begin
         side_n = CMP_W'(WIN);
      end else if (size_ext > CMP_W'(MAX_SIZE)) begin
         side_n = CMP_W'(MAX_SIZE);
      end else begin
         side_n = size_ext;
      end
   end

   // ------------------------------------------------------------ handshakes
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic out_load;
   logic s1_move;
   logic accept_in;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_load;
   assign req_stall = s1_valid_ff && !out_load;
   assign accept_in = req_valid && !req_stall;

   // ------------------------------------------------------ position counters
   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] col_cur, row_cur;
   logic [CMP_W-1:0] col_ext, row_ext;
   logic             col_wrap, row_wrap;
   logic             emit_cur, last_cur;

   always_comb begin
      col_cur = (CMP_W'(col_ff) >= side_n) ? '0 : col_ff;
      row_cur = (CMP_W'(row_ff) >= side_n) ? '0 : row_ff;
      col_ext = CMP_W'(col_cur);
      row_ext = CMP_W'(row_cur);

      col_wrap = (col_ext + CMP_W'(1)) >= side_n;
      row_wrap = (row_ext + CMP_W'(1)) >= side_n;

      if (col_wrap) begin
         col_in = '0;
         row_in = row_wrap ? '0 : row_cur + CNT_W'(1);
      end else begin
         col_in = col_cur + CNT_W'(1);
         row_in = row_cur;
      end

      emit_cur = (row_ext >= CMP_W'(WIN - 1)) && (col_ext >= CMP_W'(WIN - 1));
      last_cur = (row_ext == side_n - CMP_W'(1)) && (col_ext == side_n - CMP_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cfg_write) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept_in) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------- compute stage
   pixel_type        s1_pixel_ff;
   logic [CNT_W-1:0] s1_col_ff;
   logic             s1_emit_ff;
   logic             s1_last_ff;
   line_pair_type    above_rd;
   line_pair_type    above_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept_in) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         s1_pixel_ff <= req_pixel;
         s1_col_ff   <= col_cur;
         s1_emit_ff  <= emit_cur;
         s1_last_ff  <= last_cur;
      end
   end

   // The same column comes round again at least three beats later, so the
   // write of one beat always lands before any later read of that column.
   assign above_wr.above2 = above_rd.above;
   assign above_wr.above  = s1_pixel_ff;

   mf3_linebuf #(
      .DEPTH  (MAX_SIZE),
      .ADDR_W (CNT_W)
   ) u_linebuf (
      .clock   (clock),
      .rd_en   (accept_in),
      .rd_addr (col_cur),
      .rd_data (above_rd),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff),
      .wr_data (above_wr)
   );

   pixel_type colmax;
   pixel_type win_max;
   pixel_type colmax0_ff;
   pixel_type colmax1_ff;

   assign colmax  = max_pixel(s1_pixel_ff, max_pixel(above_rd.above, above_rd.above2));
   assign win_max = max_pixel(colmax, max_pixel(colmax0_ff, colmax1_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         colmax0_ff <= '0;
         colmax1_ff <= '0;
      end else if (s1_move) begin
         colmax1_ff <= colmax0_ff;
         colmax0_ff <= colmax;
      end
   end

   // --------------------------------------------------------- output register
   pixel_type window_max_ff;
   logic      frame_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= s1_move && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_emit_ff) begin
         window_max_ff <= win_max;
         frame_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_window_max = window_max_ff;
   assign rsp_frame_last = frame_last_ff;

endmodule
`default_nettype wire
